/* sv/bn_pkg.sv */
// ----------------------------------------------------------------------------
// bn_pkg: shared types and constants of the batch-normalization block
// Holds the transaction structs, the function codes and the sizes of the
// channel table, the job queue and the datapath.
// ----------------------------------------------------------------------------
package bn_pkg;

  localparam int MaxChannels = 512;
  localparam int ChanW       = 9;
  localparam int DataW       = 16;
  localparam int FracW       = 4;
  localparam int FracReset   = 8;
  localparam int ChAddrW     = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  localparam int QueueDepth  = 4;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);

  // Dividend magnitude is |sample - mean| << frac, at most 2^16 << 15.
  localparam int NumW        = 32;
  localparam int RemW        = 16;
  localparam int ProdW       = NumW + 1 + DataW;
  localparam int SumW        = ProdW + 1;

  localparam logic signed [SumW-1:0] SatMax = SumW'(32767);
  localparam logic signed [SumW-1:0] SatMin = -SumW'(32768);

  typedef enum logic {
    FuncLoad   = 1'b0,
    FuncSample = 1'b1
  } bn_func_e;

  typedef struct packed {
    bn_func_e                func;
    logic [ChanW-1:0]        channel;
    logic signed [DataW-1:0] sample;
    logic signed [DataW-1:0] scale;
    logic signed [DataW-1:0] offset;
    logic signed [DataW-1:0] mean_value;
    logic signed [DataW-1:0] deviation;
  } bn_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] result;
    logic [ChanW-1:0]        result_channel;
    logic                    clipped;
    logic                    zero_divisor;
  } bn_out_t;

  typedef struct packed {
    logic signed [DataW-1:0] deviation;
    logic signed [DataW-1:0] mean_value;
    logic signed [DataW-1:0] offset;
    logic signed [DataW-1:0] scale;
  } bn_param_t;

  localparam int ParamW = $bits(bn_param_t);

  typedef struct packed {
    logic [ChanW-1:0]        channel;
    logic signed [DataW-1:0] sample;
    bn_param_t               param;
    logic                    no_entry;
  } bn_job_t;

endpackage

/* sv/bn_ram.sv */
// ----------------------------------------------------------------------------
// bn_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bn_ram #(
  parameter int Width = 64,
  parameter int Depth = 512,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/bn_front.sv */
// ----------------------------------------------------------------------------
// bn_front: input side of the batch-normalization block
// Accepts transactions, writes channel parameters on loads and looks up the
// channel entry for samples, then hands each sample job to the queue.
// ----------------------------------------------------------------------------
module bn_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bn_pkg::bn_in_t        in_data_i,
  input  logic [bn_pkg::QCntW-1:0] level_i,
  output logic                  push_o,
  output bn_pkg::bn_job_t       job_o
);
  import bn_pkg::*;

  logic                    accept;
  logic                    in_range;
  logic                    we;
  logic                    re;
  logic [QCntW:0]          busy;
  logic [ParamW-1:0]       rdata;
  bn_param_t               wparam;

  logic                    f1_valid_q;
  logic [ChanW-1:0]        f1_chan_q;
  logic signed [DataW-1:0] f1_sample_q;
  logic                    f1_bad_q;

  // A job in the lookup stage still needs a queue slot.
  assign busy       = (QCntW+1)'(level_i) + (QCntW+1)'(f1_valid_q);
  assign in_stall_o = (busy >= (QCntW+1)'(QueueDepth));
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(in_data_i.channel) < 32'(MaxChannels));
  assign we         = accept && (in_data_i.func == FuncLoad) && in_range;
  assign re         = accept && (in_data_i.func == FuncSample);

  always_comb begin
    wparam.deviation  = in_data_i.deviation;
    wparam.mean_value = in_data_i.mean_value;
    wparam.offset     = in_data_i.offset;
    wparam.scale      = in_data_i.scale;
  end

  bn_ram #(
    .Width (ParamW),
    .Depth (MaxChannels),
    .AddrW (ChAddrW)
  ) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ChAddrW'(in_data_i.channel)),
    .wdata_i (wparam),
    .re_i    (re),
    .raddr_i (ChAddrW'(in_data_i.channel)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      f1_chan_q   <= in_data_i.channel;
      f1_sample_q <= in_data_i.sample;
      f1_bad_q    <= !in_range;
    end
  end

  assign push_o = f1_valid_q;

  always_comb begin
    job_o.channel  = f1_chan_q;
    job_o.sample   = f1_sample_q;
    job_o.param    = bn_param_t'(rdata);
    job_o.no_entry = f1_bad_q;
  end

endmodule

/* sv/bn_queue.sv */
// ----------------------------------------------------------------------------
// bn_queue: short job queue between front and back
// A small register FIFO that lets the two sides stall independently.
// ----------------------------------------------------------------------------
module bn_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  bn_pkg::bn_job_t          push_data_i,
  input  logic                     pop_i,
  output bn_pkg::bn_job_t          head_o,
  output logic                     empty_o,
  output logic [bn_pkg::QCntW-1:0] level_o
);
  import bn_pkg::*;

  bn_job_t          mem_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] count_q, count_d;

  always_comb begin
    wptr_d  = push_i ? wptr_q + QPtrW'(1) : wptr_q;
    rptr_d  = pop_i  ? rptr_q + QPtrW'(1) : rptr_q;
    count_d = count_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign level_o = count_q;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCntW'(QueueDepth) || pop_i))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QueueDepth))
    else $error("queue count beyond depth");
`endif

endmodule

/* sv/bn_back.sv */
// ----------------------------------------------------------------------------
// bn_back: arithmetic pipeline of the batch-normalization block
// Centers and scales the sample, divides by the deviation one quotient bit
// per stage, multiplies by the scale, adds the bias and saturates.
// ----------------------------------------------------------------------------
module bn_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [bn_pkg::FracW-1:0] frac_i,
  input  logic                     job_valid_i,
  input  bn_pkg::bn_job_t          job_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output bn_pkg::bn_out_t          out_data_o
);
  import bn_pkg::*;

  logic                    adv;

  // Entry stage inputs.
  logic signed [DataW:0]   diff;
  logic [DataW:0]          dmag;
  logic [DataW-1:0]        den;

  // Divider stages; index 0 is the entry stage.
  logic                    v_q    [NumW+1];
  logic [NumW-1:0]         num_q  [NumW+1];
  logic [RemW-1:0]         rem_q  [NumW+1];
  logic [DataW-1:0]        den_q  [NumW+1];
  logic                    neg_q  [NumW+1];
  logic                    zero_q [NumW+1];
  logic signed [DataW-1:0] scl_q  [NumW+1];
  logic signed [DataW-1:0] off_q  [NumW+1];
  logic [ChanW-1:0]        chan_q [NumW+1];

  // Multiply stage.
  logic                    m_v_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [NumW:0]    quot;
  logic                    m_neg_q, m_zero_q;
  logic signed [DataW-1:0] m_off_q;
  logic [ChanW-1:0]        m_chan_q;

  // Add stage.
  logic                    a_v_q;
  logic signed [SumW-1:0]  offs;
  logic signed [SumW-1:0]  sum_d, sum_q;
  logic                    a_zero_q;
  logic [ChanW-1:0]        a_chan_q;

  // Output register.
  logic                    out_valid_q;
  bn_out_t                 out_q, out_d;
  logic signed [SumW-1:0]  shifted;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && job_valid_i;

  always_comb begin
    diff = {job_i.sample[DataW-1], job_i.sample}
         - {job_i.param.mean_value[DataW-1], job_i.param.mean_value};
    dmag = diff[DataW] ? (DataW+1)'(-diff) : diff;
    den  = job_i.param.deviation[DataW-1] ? DataW'(-job_i.param.deviation)
                                          : job_i.param.deviation;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q[0]  <= NumW'(dmag) << frac_i;
      rem_q[0]  <= '0;
      den_q[0]  <= den;
      neg_q[0]  <= diff[DataW] ^ job_i.param.deviation[DataW-1];
      zero_q[0] <= job_i.no_entry || (job_i.param.deviation == '0);
      scl_q[0]  <= job_i.param.scale;
      off_q[0]  <= job_i.param.offset;
      chan_q[0] <= job_i.channel;
    end
  end

  // Restoring division of magnitudes, one quotient bit per stage. The
  // quotient bits shift into the low end of the dividend register.
  for (genvar k = 0; k < NumW; k++) begin : g_div
    logic [RemW:0] part;
    logic [RemW:0] sub;
    logic          ge;

    assign part = {rem_q[k], num_q[k][NumW-1]};
    assign sub  = part - {1'b0, den_q[k]};
    assign ge   = (part >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (adv) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        num_q[k+1]  <= {num_q[k][NumW-2:0], ge};
        rem_q[k+1]  <= ge ? sub[RemW-1:0] : part[RemW-1:0];
        den_q[k+1]  <= den_q[k];
        neg_q[k+1]  <= neg_q[k];
        zero_q[k+1] <= zero_q[k];
        scl_q[k+1]  <= scl_q[k];
        off_q[k+1]  <= off_q[k];
        chan_q[k+1] <= chan_q[k];
      end
    end
  end

  assign quot = $signed({1'b0, num_q[NumW]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      a_v_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      m_v_q <= v_q[NumW];
      a_v_q <= m_v_q;
      out_valid_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q   <= quot * scl_q[NumW];
      m_neg_q  <= neg_q[NumW];
      m_zero_q <= zero_q[NumW];
      m_off_q  <= off_q[NumW];
      m_chan_q <= chan_q[NumW];
    end
  end

  // The quotient sign is folded into the add, so the multiplier only sees the
  // quotient magnitude.
  always_comb begin
    offs  = SumW'(m_off_q) <<< frac_i;
    sum_d = m_neg_q ? offs - SumW'(prod_q) : offs + SumW'(prod_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q    <= sum_d;
      a_zero_q <= m_zero_q;
      a_chan_q <= m_chan_q;
      out_q    <= out_d;
    end
  end

  always_comb begin
    shifted              = sum_q >>> frac_i;
    out_d.result_channel = a_chan_q;
    out_d.zero_divisor   = a_zero_q;
    out_d.clipped        = 1'b0;
    out_d.result         = shifted[DataW-1:0];
    if (a_zero_q) begin
      out_d.result = '0;
    end else if (shifted > SatMax) begin
      out_d.result  = DataW'(SatMax);
      out_d.clipped = 1'b1;
    end else if (shifted < SatMin) begin
      out_d.result  = DataW'(SatMin);
      out_d.clipped = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_divisor) |->
      (out_data_o.result == '0 && !out_data_o.clipped))
    else $error("zero divisor with nonzero result");

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.clipped) |->
      (out_data_o.result == DataW'(SatMax) || out_data_o.result == DataW'(SatMin)))
    else $error("clipped result not at a bound");

  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> job_valid_i && adv)
    else $error("pop without job or while frozen");
`endif

endmodule

/* sv/batchnorm_inference_fixed.sv */
// Throughput: one item per cycle while out_stall_i is low; the divider pipeline has 32 stages.
// Load transactions produce no result; they write the channel table when the channel is in range.
// Reset is asynchronous, active low; it clears control state and sets frac_bits to 8.
// The channel table has no reset; a channel must be loaded before it is sampled.
// ----------------------------------------------------------------------------
// batchnorm_inference_fixed: fixed-point batch-normalization inference
// Front end with channel table, job queue and pipelined arithmetic back end.
// ----------------------------------------------------------------------------
module batchnorm_inference_fixed (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bn_pkg::FracW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  bn_pkg::bn_in_t           in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output bn_pkg::bn_out_t          out_data_o
);
  import bn_pkg::*;

  logic [FracW-1:0] frac_q;
  logic             push;
  bn_job_t          push_job;
  bn_job_t          head;
  logic             empty;
  logic             pop;
  logic [QCntW-1:0] level;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= FracW'(FracReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      frac_q <= cfg_data_i;
    end
  end

  bn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .level_i    (level),
    .push_o     (push),
    .job_o      (push_job)
  );

  bn_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .level_o     (level)
  );

  bn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frac_i      (frac_q),
    .job_valid_i (!empty),
    .job_i       (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
